FILE: rtl/cmfu_pkg.sv
// shared types and constants for the motor feedback unwrap block
`default_nettype none

package cmfu_pkg;

  localparam int ID_W           = 11;
  localparam int PAYLOAD_W      = 64;
  localparam int IDX_W          = 4;
  localparam int MOTORS_PER_BUS = 11;
  localparam int BUS_COUNT      = 2;
  localparam int SLOTS          = BUS_COUNT * MOTORS_PER_BUS;
  localparam int SLOT_W         = $clog2(SLOTS);
  localparam int MASK_W         = 22;
  localparam int GAIN_W         = 16;
  localparam int CFG_DATA_W     = 22;
  localparam int CFG_IDX_W      = 2;

  localparam logic [ID_W-1:0] ID_FIRST = 11'h201;
  localparam logic [ID_W-1:0] ID_LAST  = 11'h20B;

  localparam int COUNTS_PER_REV = 8192;
  localparam int REV_SHIFT      = $clog2(COUNTS_PER_REV);
  localparam int HALF_REV       = COUNTS_PER_REV / 2;
  // total angle = total * 360 * 256 / counts per rev = total * ANGLE_NUM / 2**ANGLE_SHIFT
  localparam int ANGLE_SHIFT    = 2;
  localparam int ANGLE_NUM      = 360 * 256 * (1 << ANGLE_SHIFT) / COUNTS_PER_REV;
  localparam int SPEED_SCALE    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_ON_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN    = 2'd2;

  localparam logic [MASK_W-1:0] ENABLE_RESET = '0;
  localparam logic [MASK_W-1:0] ZOS_RESET    = '1;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd256;

  typedef struct packed {
    logic [MASK_W-1:0] enable_mask;
    logic [MASK_W-1:0] zero_on_start_mask;
    logic [GAIN_W-1:0] speed_gain_q8;
  } cfg_t;

  typedef struct packed {
    logic                 bus;
    logic [ID_W-1:0]      frame_id;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

  typedef struct packed {
    logic               bus;
    logic [IDX_W-1:0]   motor_index;
    logic               calibrating;
    logic signed [17:0] angle;
    logic signed [31:0] round;
    logic signed [47:0] speed_sum;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         temperature;
  } track_t;

endpackage

`default_nettype wire

FILE: rtl/cmfu_if.sv
// input frame and result channel interfaces
`default_nettype none

interface cmfu_in_if import cmfu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 bus;
  logic [ID_W-1:0]      frame_id;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, output bus, output frame_id, output payload, input ready);
  modport sink   (input valid, input bus, input frame_id, input payload, output ready);
endinterface

interface cmfu_out_if import cmfu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               bus_out;
  logic [IDX_W-1:0]   motor_index;
  logic               calibrating;
  logic signed [16:0] angle_corrected;
  logic signed [31:0] round_count;
  logic signed [47:0] total_count;
  logic signed [47:0] total_angle_q8;
  logic signed [34:0] rate_q8;
  logic signed [47:0] speed_sum;
  logic signed [15:0] current;
  logic [7:0]         temperature;

  modport source (
    output valid, output bus_out, output motor_index, output calibrating,
    output angle_corrected, output round_count, output total_count,
    output total_angle_q8, output rate_q8, output speed_sum, output current,
    output temperature, input ready
  );
  modport sink (
    input valid, input bus_out, input motor_index, input calibrating,
    input angle_corrected, input round_count, input total_count,
    input total_angle_q8, input rate_q8, input speed_sum, input current,
    input temperature, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/can_motor_feedback_unwrap.sv
// top level: configuration registers, input register and the two processing parts
//
// Takes one motor feedback frame per cycle unless the output stalls, and returns one result
// word for each frame whose id lies in 0x201..0x20B and whose motor is enabled; other frames
// are dropped silently. The first two frames of a motor are calibration frames. A result
// passes the input register, per-motor unwrap stage, total count stage and result register;
// the per-motor state is read, updated and written back in the single unwrap stage, so frames
// for the same motor may follow each other directly. Configuration writes take effect on the
// next cycle and should be made while the block is idle.
`default_nettype none

module can_motor_feedback_unwrap import cmfu_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cmfu_in_if.sink                    in_word,
  cmfu_out_if.source                 out_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  logic   s1_valid_r;
  frame_t s1_frame_r;
  logic   s1_ready;
  logic   s2_valid;
  logic   s2_ready;
  track_t s2_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask        <= ENABLE_RESET;
      cfg_r.zero_on_start_mask <= ZOS_RESET;
      cfg_r.speed_gain_q8      <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:        cfg_r.enable_mask        <= cfg_wdata[MASK_W-1:0];
        CFG_ZERO_ON_START: cfg_r.zero_on_start_mask <= cfg_wdata[MASK_W-1:0];
        CFG_SPEED_GAIN:    cfg_r.speed_gain_q8      <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign in_word.ready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      s1_valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.ready) begin
      s1_frame_r.bus      <= in_word.bus;
      s1_frame_r.frame_id <= in_word.frame_id;
      s1_frame_r.payload  <= in_word.payload;
    end
  end

  cmfu_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s1_valid (s1_valid_r),
    .s1_ready (s1_ready),
    .s1_frame (s1_frame_r),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data)
  );

  cmfu_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

FILE: rtl/cmfu_track.sv
// per-motor state and the read-modify-write unwrap stage
`default_nettype none

module cmfu_track import cmfu_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   s1_valid,
  output logic        s1_ready,
  input  wire frame_t s1_frame,
  output logic        s2_valid,
  input  wire logic   s2_ready,
  output track_t      s2_data
);

  logic [15:0]        offset_r     [SLOTS];
  logic signed [17:0] last_r       [SLOTS];
  logic signed [31:0] round_r      [SLOTS];
  logic signed [47:0] ssum_r       [SLOTS];
  logic [1:0]         fcnt_r       [SLOTS];

  logic               s2_valid_r;
  track_t             s2_data_r;
  track_t             s2_data_nxt;

  logic               in_range;
  logic [IDX_W-1:0]   idx;
  logic [SLOT_W-1:0]  slot;
  logic               hit;
  logic               fire;
  logic               calib;
  logic signed [15:0] enc;
  logic signed [15:0] spd;
  logic signed [15:0] offset;
  logic signed [17:0] cal0;
  logic signed [17:0] cal;
  logic signed [18:0] diff;
  logic signed [31:0] round_nxt;
  logic signed [47:0] ssum_nxt;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign fire     = s1_valid && s1_ready;
  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_data_r;

  always_comb begin
    in_range = (s1_frame.frame_id >= ID_FIRST) && (s1_frame.frame_id <= ID_LAST);
    idx      = IDX_W'(s1_frame.frame_id - ID_FIRST);
    slot     = (s1_frame.bus ? SLOT_W'(MOTORS_PER_BUS) : '0) + SLOT_W'(idx);
    hit      = in_range && (idx < IDX_W'(MOTORS_PER_BUS)) && cfg.enable_mask[slot];

    enc    = $signed(s1_frame.payload[63:48]);
    spd    = $signed(s1_frame.payload[47:32]);
    offset = $signed(offset_r[slot]);
    calib  = (fcnt_r[slot] < 2'd2);

    // corrected angle, wrapped once into half a turn either way
    cal0 = 18'(enc) - 18'(offset);
    if (cal0 > $signed(18'(HALF_REV))) begin
      cal = cal0 - $signed(18'(COUNTS_PER_REV));
    end else if (cal0 < -$signed(18'(HALF_REV))) begin
      cal = cal0 + $signed(18'(COUNTS_PER_REV));
    end else begin
      cal = cal0;
    end

    // round counter steps on a jump of more than half a turn
    diff = 19'(cal) - 19'(last_r[slot]);
    if (diff > $signed(19'(HALF_REV))) begin
      round_nxt = round_r[slot] - 32'sd1;
    end else if (diff < -$signed(19'(HALF_REV))) begin
      round_nxt = round_r[slot] + 32'sd1;
    end else begin
      round_nxt = round_r[slot];
    end

    ssum_nxt = ssum_r[slot] + 48'(spd);

    s2_data_nxt.bus         = s1_frame.bus;
    s2_data_nxt.motor_index = idx;
    s2_data_nxt.calibrating = calib;
    s2_data_nxt.current     = $signed(s1_frame.payload[31:16]);
    s2_data_nxt.temperature = s1_frame.payload[15:8];
    if (calib) begin
      s2_data_nxt.angle     = '0;
      s2_data_nxt.round     = '0;
      s2_data_nxt.speed_sum = '0;
      s2_data_nxt.speed     = '0;
    end else begin
      s2_data_nxt.angle     = cal;
      s2_data_nxt.round     = round_nxt;
      s2_data_nxt.speed_sum = ssum_nxt;
      s2_data_nxt.speed     = spd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        offset_r[i] <= '0;
        last_r[i]   <= '0;
        round_r[i]  <= '0;
        ssum_r[i]   <= '0;
        fcnt_r[i]   <= '0;
      end
    end else begin
      if (s1_ready) begin
        s2_valid_r <= s1_valid && hit;
      end
      if (fire && hit) begin
        if (calib) begin
          fcnt_r[slot]  <= fcnt_r[slot] + 2'd1;
          round_r[slot] <= '0;
          ssum_r[slot]  <= '0;
          if (cfg.zero_on_start_mask[slot]) begin
            offset_r[slot] <= s1_frame.payload[63:48];
          end
        end else begin
          last_r[slot]  <= cal;
          round_r[slot] <= round_nxt;
          ssum_r[slot]  <= ssum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s2_data_r <= s2_data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cmfu_scale.sv
// total count, total angle and rate stages feeding the result register
`default_nettype none

module cmfu_scale import cmfu_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   s2_valid,
  output logic        s2_ready,
  input  wire track_t s2_data,
  cmfu_out_if.source  out_word
);

  logic               s3_valid_r;
  track_t             s3_trk_r;
  logic signed [47:0] tot_r;
  logic signed [32:0] prod_r;
  logic               out_valid_r;
  logic               out_free;

  logic signed [47:0] tot_nxt;
  logic signed [32:0] prod_nxt;
  logic signed [53:0] ang_prod;
  logic signed [53:0] ang_biased;
  logic signed [53:0] ang_q;
  logic signed [35:0] rate_w;

  logic               bus_r;
  logic [IDX_W-1:0]   idx_r;
  logic               calib_r;
  logic signed [16:0] angle_r;
  logic signed [31:0] round_r;
  logic signed [47:0] total_r;
  logic signed [47:0] tangle_r;
  logic signed [34:0] rate_r;
  logic signed [47:0] ssum_r;
  logic signed [15:0] current_r;
  logic [7:0]         temp_r;

  assign out_free = !out_valid_r || out_word.ready;
  assign s2_ready = !s3_valid_r || out_free;

  always_comb begin
    tot_nxt  = (48'(s2_data.round) <<< REV_SHIFT)
             + 48'(s2_data.angle);
    prod_nxt = $signed({{17{s2_data.speed[15]}}, s2_data.speed})
             * $signed({17'b0, cfg.speed_gain_q8});

    // exact scale then truncate toward zero
    ang_prod   = 54'(tot_r) * $signed(54'(ANGLE_NUM));
    ang_biased = ang_prod + (tot_r[47] ? $signed(54'((1 << ANGLE_SHIFT) - 1)) : 54'sd0);
    ang_q      = ang_biased >>> ANGLE_SHIFT;
    rate_w     = 36'(prod_r) * $signed(36'(SPEED_SCALE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s3_valid_r <= s2_valid;
      end
      if (out_free) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s3_trk_r <= s2_data;
      tot_r    <= tot_nxt;
      prod_r   <= prod_nxt;
    end
    if (out_free) begin
      bus_r     <= s3_trk_r.bus;
      idx_r     <= s3_trk_r.motor_index;
      calib_r   <= s3_trk_r.calibrating;
      angle_r   <= s3_trk_r.angle[16:0];
      round_r   <= s3_trk_r.round;
      total_r   <= tot_r;
      tangle_r  <= ang_q[47:0];
      rate_r    <= rate_w[34:0];
      ssum_r    <= s3_trk_r.speed_sum;
      current_r <= s3_trk_r.current;
      temp_r    <= s3_trk_r.temperature;
    end
  end

  assign out_word.valid           = out_valid_r;
  assign out_word.bus_out         = bus_r;
  assign out_word.motor_index     = idx_r;
  assign out_word.calibrating     = calib_r;
  assign out_word.angle_corrected = angle_r;
  assign out_word.round_count     = round_r;
  assign out_word.total_count     = total_r;
  assign out_word.total_angle_q8  = tangle_r;
  assign out_word.rate_q8         = rate_r;
  assign out_word.speed_sum       = ssum_r;
  assign out_word.current         = current_r;
  assign out_word.temperature     = temp_r;

endmodule

`default_nettype wire

FILE: sim/unwrap_checker.sv
// checker for the motor feedback unwrap block: per-motor predictor and in-order result compare
module unwrap_checker import cmfu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cmfu_in_if                    in_mon,
  cmfu_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    calibrations
);

  localparam longint Q8_DEG_PER_REV = 360 * 256;

  typedef struct packed {
    logic             bus;
    logic [IDX_W-1:0] motor;
    logic             calibrating;
    logic [16:0]      angle;
    logic [31:0]      rounds;
    logic [47:0]      total;
    logic [47:0]      total_angle;
    logic [34:0]      rate;
    logic [47:0]      speed_sum;
    logic [15:0]      current;
    logic [7:0]       temperature;
  } feedback_t;

  logic [MASK_W-1:0] enable_q;
  logic [MASK_W-1:0] zos_q;
  logic [GAIN_W-1:0] gain_q;

  logic [15:0]        offset_q  [SLOTS];
  logic signed [17:0] last_q    [SLOTS];
  logic [31:0]        rounds_q  [SLOTS];
  logic [47:0]        spsum_q   [SLOTS];
  logic [1:0]         seen_q    [SLOTS];

  feedback_t feedback_due [$];
  int errors = 0;
  int compared = 0;
  int calib_compared = 0;

  assign fail_count   = errors;
  assign checked      = compared;
  assign calibrations = calib_compared;

  function automatic bit unwrap_frame(input logic bus, input logic [ID_W-1:0] id,
                                      input logic [PAYLOAD_W-1:0] pl, output feedback_t fb);
    int idx;
    int slot;
    longint enc;
    longint spd;
    longint cal;
    longint prev;
    longint jump;
    longint tot;
    longint whole;
    longint part;
    longint ang;
    logic [47:0] tot48;
    fb = '0;
    if (id < ID_FIRST || id > ID_LAST) return 1'b0;
    idx = int'(id - ID_FIRST);
    if (idx >= MOTORS_PER_BUS || int'(bus) >= BUS_COUNT) return 1'b0;
    slot = int'(bus) * MOTORS_PER_BUS + idx;
    if (!enable_q[slot]) return 1'b0;

    enc = longint'($signed(pl[63:48]));
    spd = longint'($signed(pl[47:32]));
    fb.bus = bus;
    fb.motor = IDX_W'(idx);
    fb.current = pl[31:16];
    fb.temperature = pl[15:8];

    // first two frames of a motor: clear the totals, optionally latch the zero
    if (seen_q[slot] < 2'd2) begin
      seen_q[slot] = seen_q[slot] + 2'd1;
      if (zos_q[slot]) offset_q[slot] = pl[63:48];
      rounds_q[slot] = '0;
      spsum_q[slot] = '0;
      fb.calibrating = 1'b1;
      return 1'b1;
    end

    cal = enc - longint'($signed(offset_q[slot]));
    if (cal > HALF_REV) cal = cal - COUNTS_PER_REV;
    else if (cal < -HALF_REV) cal = cal + COUNTS_PER_REV;

    prev = longint'(last_q[slot]);
    jump = cal - prev;
    if (jump > HALF_REV) rounds_q[slot] = rounds_q[slot] - 32'd1;
    else if (jump < -HALF_REV) rounds_q[slot] = rounds_q[slot] + 32'd1;
    last_q[slot] = 18'(cal);

    tot48 = 48'(longint'($signed(rounds_q[slot])) * COUNTS_PER_REV + cal);
    tot = longint'($signed(tot48));
    whole = tot / COUNTS_PER_REV;
    part = tot % COUNTS_PER_REV;
    ang = whole * Q8_DEG_PER_REV + (part * Q8_DEG_PER_REV) / COUNTS_PER_REV;

    spsum_q[slot] = spsum_q[slot] + 48'(spd);

    fb.angle = 17'(cal);
    fb.rounds = rounds_q[slot];
    fb.total = tot48;
    fb.total_angle = 48'(ang);
    fb.rate = 35'(spd * SPEED_SCALE * longint'(gain_q));
    fb.speed_sum = spsum_q[slot];
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("result %0d %s: expected %h, got %h", compared, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    feedback_t want;
    if (!rst_n) begin
      enable_q = ENABLE_RESET;
      zos_q = ZOS_RESET;
      gain_q = GAIN_RESET;
      foreach (offset_q[i]) begin
        offset_q[i] = '0;
        last_q[i] = '0;
        rounds_q[i] = '0;
        spsum_q[i] = '0;
        seen_q[i] = '0;
      end
      feedback_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:        enable_q = cfg_wdata[MASK_W-1:0];
          CFG_ZERO_ON_START: zos_q = cfg_wdata[MASK_W-1:0];
          CFG_SPEED_GAIN:    gain_q = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready &&
          unwrap_frame(in_mon.bus, in_mon.frame_id, in_mon.payload, want))
        feedback_due.push_back(want);
      if (out_mon.valid && out_mon.ready) begin
        if (feedback_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result for bus %0d motor %0d", out_mon.bus_out,
                     out_mon.motor_index);
        end else begin
          want = feedback_due.pop_front();
          check_field("bus_out", want.bus, out_mon.bus_out);
          check_field("motor_index", want.motor, out_mon.motor_index);
          check_field("calibrating", want.calibrating, out_mon.calibrating);
          check_field("angle_corrected", want.angle, $unsigned(out_mon.angle_corrected));
          check_field("round_count", want.rounds, $unsigned(out_mon.round_count));
          check_field("total_count", want.total, $unsigned(out_mon.total_count));
          check_field("total_angle_q8", want.total_angle, $unsigned(out_mon.total_angle_q8));
          check_field("rate_q8", want.rate, $unsigned(out_mon.rate_q8));
          check_field("speed_sum", want.speed_sum, $unsigned(out_mon.speed_sum));
          check_field("current", want.current, $unsigned(out_mon.current));
          check_field("temperature", want.temperature, out_mon.temperature);
          if (want.calibrating) calib_compared++;
          compared++;
        end
      end
    end
    pending <= feedback_due.size();
  end

endmodule

FILE: sim/tb.sv
// testbench top for the motor feedback unwrap block: clock, reset, stimulus and verdict
module tb;
  import cmfu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [MASK_W-1:0]    ALL_MOTORS = '1;
  localparam int TARGET_FRAMES = 1750;
  localparam int RANDOM_PHASES = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 1000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  sink_ready = 1'b0;

  int stall_mode = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int frames_sent = 0;
  int phases = 0;
  int motor_now = 0;
  logic [12:0] shaft_pos [SLOTS];

  int fail_count;
  int pending;
  int checked;
  int calibrations;

  cmfu_in_if  in_word ();
  cmfu_out_if out_word ();
  assign out_word.ready = sink_ready;

  can_motor_feedback_unwrap dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  unwrap_checker unwrap_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_word),
    .out_mon      (out_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .calibrations (calibrations)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: phases of always ready, mostly ready and mostly stalled
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: sink_ready <= 1'b1;
      1: sink_ready <= ($urandom_range(0, 3) != 0);
      default: sink_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("can_motor_feedback_unwrap test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [PAYLOAD_W-1:0] frame_bytes(input logic [15:0] enc,
      input logic [15:0] spd, input logic [15:0] cur, input logic [7:0] temp,
      input logic [7:0] pad);
    return {enc, spd, cur, temp, pad};
  endfunction

  task automatic send_frame(input logic bus, input logic [ID_W-1:0] id,
                            input logic [PAYLOAD_W-1:0] pl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_word.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_word.valid <= 1'b1;
    in_word.bus <= bus;
    in_word.frame_id <= id;
    in_word.payload <= pl;
    do @(posedge clk); while (!in_word.ready);
    frames_sent++;
  endtask

  task automatic drain();
    in_word.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [MASK_W-1:0] en, input logic [MASK_W-1:0] zos,
                           input logic [GAIN_W-1:0] gain);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    drain();
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_ZERO_ON_START, zos);
    write_reg(CFG_SPEED_GAIN, {junk[CFG_DATA_W-1:GAIN_W], gain});
    write_reg(CFG_UNUSED, junk);
    cfg_we <= 1'b0;
    phases++;
  endtask

  // mostly motors turning in runs, with some stray ids and raw encoder words
  task automatic random_frame();
    int roll;
    int jump;
    logic [15:0] enc;
    logic [ID_W-1:0] id;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      if (roll < 4) id = ID_W'($urandom);
      else if (roll < 6) id = ID_FIRST - ID_W'(1);
      else id = ID_LAST + ID_W'(1);
      send_frame(1'($urandom), id, {$urandom, $urandom});
    end else begin
      if (roll < 35) motor_now = $urandom_range(0, SLOTS - 1);
      jump = (roll < 90) ? $urandom_range(0, 6000) - 3000 : $urandom_range(0, 16382) - 8191;
      shaft_pos[motor_now] = shaft_pos[motor_now] + 13'(jump);
      enc = (roll < 96) ? {3'b000, shaft_pos[motor_now]} : 16'($urandom);
      send_frame(motor_now >= MOTORS_PER_BUS, ID_FIRST + ID_W'(motor_now % MOTORS_PER_BUS),
                 {enc, 48'({$urandom, $urandom})});
    end
  endtask

  initial begin
    int goal;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_wdata = '0;
    in_word.valid = 1'b0;
    in_word.bus = 1'b0;
    in_word.frame_id = '0;
    in_word.payload = '0;
    foreach (shaft_pos[i]) shaft_pos[i] = 13'($urandom);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // all motors disabled out of reset
    send_frame(1'b0, ID_FIRST, frame_bytes(16'h0100, 16'h0001, 16'h0002, 8'h03, 8'h04));
    send_frame(1'b1, ID_LAST, '1);

    configure(ALL_MOTORS, 22'h2AAAAA, 16'hFFFF);
    send_frame(1'b0, ID_FIRST - ID_W'(1), '1);
    send_frame(1'b1, ID_LAST + ID_W'(1), '1);
    send_frame(1'b0, '0, '0);
    send_frame(1'b1, '1, '1);
    // calibration, zero offset kept on bus 0 motor 0, latched on motor 1
    send_frame(1'b0, ID_FIRST, frame_bytes(16'h1000, 16'h7FFF, 16'h8000, 8'hFF, 8'h00));
    send_frame(1'b0, ID_FIRST, frame_bytes(16'h1FFF, 16'h7FFF, 16'h8000, 8'hFF, 8'h00));
    send_frame(1'b0, ID_FIRST + ID_W'(1),
               frame_bytes(16'h0100, 16'h0010, 16'h0020, 8'h30, 8'h40));
    send_frame(1'b0, ID_FIRST + ID_W'(1),
               frame_bytes(16'h0123, 16'h0010, 16'h0020, 8'h30, 8'h40));
    // half-turn wraps and round steps both ways
    send_frame(1'b0, ID_FIRST, frame_bytes(16'h0000, 16'h8000, 16'h7FFF, 8'h00, 8'hFF));
    send_frame(1'b0, ID_FIRST, frame_bytes(16'h1FFF, 16'h8000, 16'h7FFF, 8'h00, 8'hFF));
    send_frame(1'b0, ID_FIRST, frame_bytes(16'h1000, 16'h7FFF, 16'h8000, 8'hFF, 8'h00));
    send_frame(1'b0, ID_FIRST, frame_bytes(16'h1001, 16'h7FFF, 16'h8000, 8'hFF, 8'h00));
    send_frame(1'b0, ID_FIRST, frame_bytes(16'hFFFF, 16'h0001, 16'hFFFF, 8'h01, 8'h00));
    send_frame(1'b0, ID_FIRST, frame_bytes(16'h8000, 16'h8000, 16'h8000, 8'h80, 8'h80));
    send_frame(1'b0, ID_FIRST, frame_bytes(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h7F, 8'h7F));
    send_frame(1'b0, ID_FIRST + ID_W'(1), '1);
    send_frame(1'b1, ID_LAST, '0);
    send_frame(1'b1, ID_LAST, '1);
    send_frame(1'b1, ID_LAST, frame_bytes(16'h8000, 16'h8000, 16'h8000, 8'h80, 8'h01));

    // one motor switched off, zero gain
    configure(ALL_MOTORS ^ MASK_W'(1), ALL_MOTORS, '0);
    send_frame(1'b0, ID_FIRST, '1);
    send_frame(1'b0, ID_FIRST + ID_W'(1),
               frame_bytes(16'h0200, 16'h7FFF, 16'h1234, 8'h56, 8'h78));

    configure('0, '0, GAIN_RESET);
    send_frame(1'b0, ID_FIRST + ID_W'(1), '1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(ALL_MOTORS, MASK_W'($urandom), GAIN_RESET);
        1: configure(MASK_W'($urandom | $urandom), '0, '1);
        2: configure(MASK_W'($urandom | $urandom), ALL_MOTORS, '0);
        default: configure(MASK_W'($urandom | $urandom), MASK_W'($urandom), GAIN_W'($urandom));
      endcase
      goal = frames_sent + (TARGET_FRAMES - frames_sent) / (RANDOM_PHASES - p);
      while (frames_sent < goal) begin
        random_frame();
        if ($urandom_range(0, 299) == 0) drain();
      end
    end

    drain();
    $display("%0d frames driven, %0d results checked (%0d calibration) over %0d settings",
             frames_sent, checked, calibrations, phases);
    if (fail_count == 0 && pending == 0) begin
      $display("can_motor_feedback_unwrap test passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("can_motor_feedback_unwrap test failed");
    end
    $finish;
  end

endmodule
